FILE: hw/rtl/sobel_gradient_magnitude_unit_macros.svh
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_UNIT_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define SGM_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
    else $error("sgm check failed");

// Next-cycle implication, off while reset is asserted.
`define SGM_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
    else $error("sgm check failed");

// Holds in the cycle after any edge that samples reset asserted.
`define SGM_ASSERT_AFTER_RESET(lbl, ck, rs, cons) \
  lbl: assert property (@(posedge ck) (!rs) |=> (cons)) \
    else $error("sgm reset check failed");

`endif

FILE: hw/rtl/sgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: shared package
// Register indexes, fixed field widths, scaling constants and the side-band
// tag that travels down the square-root pipeline.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 13;
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;
  localparam int ROW_W       = 12;
  localparam int MAG_W       = 10;
  localparam int OUT_DW      = 16;

  typedef enum logic [CFG_AW-1:0] {
    REG_IN_WIDTH  = 2'd0,
    REG_IN_HEIGHT = 2'd1,
    REG_EN_HORIZ  = 2'd2,
    REG_EN_VERT   = 2'd3
  } cfg_reg_t;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd1024;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = 13'd3;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX   = 13'd4096;
  localparam logic [ROW_W-1:0]       ROW_LAST_MIN = 12'd2;
  localparam logic [ROW_W-1:0]       ROW_LAST_MAX = 12'd4095;
  localparam logic [ROW_W-1:0]       ROW_FIRST_RES = 12'd2;

  localparam logic [MAG_W-1:0] MAG_MAX = 10'd1023;

  // floor(r * 100 / 141) equals (r * SCALE_MUL) >> SCALE_SHIFT for r below
  // ROOT_SAT; from ROOT_SAT up the scaled value exceeds MAG_MAX.
  localparam logic [25:0] SCALE_MUL   = 26'd47595000;
  localparam int          SCALE_SHIFT = 26;
  localparam int          ROOT_SAT    = 1444;
  localparam int          ROOT_USE_W  = 11;

  typedef struct packed {
    logic             last_row;
    logic             last_frame;
    logic             both;
    logic [MAG_W-1:0] lin_mag;
  } tag_t;

endpackage

FILE: hw/rtl/sgm_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: line store
// One row of pixels in a single-port-read, single-port-write synchronous
// memory with registered read data.
// ----------------------------------------------------------------------------
module sgm_line_store #(
  parameter int DEPTH = 1024,
  parameter int DW    = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // A read and a write to the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/sgm_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: square-root pipeline
// Integer square root by the digit method, one result bit per stage, with a
// side-band tag carried alongside. All stages advance together on en.
// ----------------------------------------------------------------------------
module sgm_isqrt #(
  parameter int RW = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_value,
  input  sgm_pkg::tag_t     in_tag,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output sgm_pkg::tag_t     out_tag
);

  localparam int RMW = RW + 2;

  logic              vld_r   [RW];
  logic [RW-1:0]     root_r  [RW];
  sgm_pkg::tag_t     tag_r   [RW];
  logic [RW-1:0]     rem_r   [RW-1];
  logic [2*RW-1:0]   nrest_r [RW-1];

  genvar i;
  generate
    for (i = 0; i < RW; i++) begin : g_stage
      logic [RW-1:0]   rem_in;
      logic [RW-1:0]   root_in;
      logic [2*RW-1:0] nrest_in;
      logic            v_in;
      sgm_pkg::tag_t   tag_in;
      logic [RMW-1:0]  rem_sh;
      logic [RMW-1:0]  trial;
      logic            take;
      logic [RW-1:0]   root_nxt;

      if (i == 0) begin : g_first
        assign rem_in   = '0;
        assign root_in  = '0;
        assign nrest_in = in_value;
        assign v_in     = in_valid;
        assign tag_in   = in_tag;
      end else begin : g_next
        assign rem_in   = rem_r[i-1];
        assign root_in  = root_r[i-1];
        assign nrest_in = nrest_r[i-1];
        assign v_in     = vld_r[i-1];
        assign tag_in   = tag_r[i-1];
      end

      // Bring down the next two radicand bits and try root*4+1.
      assign rem_sh   = {rem_in, nrest_in[2*RW-1 -: 2]};
      assign trial    = {root_in, 2'b01};
      assign take     = (rem_sh >= trial);
      assign root_nxt = {root_in[RW-2:0], take};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (en) begin
          vld_r[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          root_r[i] <= root_nxt;
          tag_r[i]  <= tag_in;
        end
      end

      if (i < RW - 1) begin : g_carry
        logic [RMW-1:0] rem_dif;

        assign rem_dif = rem_sh - trial;

        // The remainder stays below 2**RW until the last stage.
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[i]   <= take ? rem_dif[RW-1:0] : rem_sh[RW-1:0];
            nrest_r[i] <= {nrest_in[2*RW-3:0], 2'b00};
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_tag   = tag_r[RW-1];

endmodule

FILE: hw/rtl/sobel_gradient_magnitude_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient magnitude unit
// 3x3 Sobel edge detector over a padded luma raster. Two line stores hold the
// rows above, a six-pixel window holds the two previous columns.
//
//   Channel | Handshake               | Contents
//   in_     | in_tvalid / in_tready   | tdata: pixel; tuser: start_of_frame
//   out_    | out_tvalid / out_tready | tdata: magnitude; tlast: last_in_row;
//           |                         | tuser: last_in_frame
//   cfg_    | cfg_we                  | cfg_addr: register; cfg_wdata: value
//
// One word per clock sustained while the output is not held. A result passes
// through stage 1 (line-store read), stage 2 (gradients), stage 3 (squares),
// one square-root stage per result bit (PIXEL_BITS+3 stages), then scaling.
// Reset clears counters and valid bits and presets configuration, not the line
// stores. The whole pipeline holds while an output word waits (in_tready low).
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  localparam int IN_DW     = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [sgm_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [sgm_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_DW-1:0]           in_tdata,   // [PIXEL_BITS-1:0] pixel
  input  logic                       in_tuser,   // [0] start_of_frame
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [sgm_pkg::OUT_DW-1:0] out_tdata,  // [9:0] magnitude
  output logic                       out_tlast,
  output logic                       out_tuser   // [0] last_in_frame
);

  localparam int P   = PIXEL_BITS;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > sgm_pkg::WIDTH_BITS) ?
                       $clog2(MAX_WIDTH + 1) : sgm_pkg::WIDTH_BITS;
  localparam int SW  = P + 2;
  localparam int GW  = P + 3;
  localparam int RW  = SW + 1;
  localparam int LXW = (GW + 1 > sgm_pkg::MAG_W) ? GW + 1 : sgm_pkg::MAG_W;
  localparam int RXW = (RW > sgm_pkg::ROOT_USE_W) ? RW : sgm_pkg::ROOT_USE_W;
  localparam int PW  = sgm_pkg::ROOT_USE_W + 26;
  localparam int RW_ROW = sgm_pkg::ROW_W;

  // Configuration registers.
  logic [sgm_pkg::WIDTH_BITS-1:0]  in_width_r;
  logic [sgm_pkg::HEIGHT_BITS-1:0] in_height_r;
  logic                            en_h_r;
  logic                            en_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r  <= sgm_pkg::WIDTH_RESET;
      in_height_r <= sgm_pkg::HEIGHT_RESET;
      en_h_r      <= 1'b1;
      en_v_r      <= 1'b1;
    end else if (cfg_we) begin
      case (sgm_pkg::cfg_reg_t'(cfg_addr))
        sgm_pkg::REG_IN_WIDTH:  in_width_r  <= cfg_wdata[sgm_pkg::WIDTH_BITS-1:0];
        sgm_pkg::REG_IN_HEIGHT: in_height_r <= cfg_wdata;
        sgm_pkg::REG_EN_HORIZ:  en_h_r      <= cfg_wdata[0];
        sgm_pkg::REG_EN_VERT:   en_v_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamped last column and last row.
  logic [WW-1:0]     width_x;
  logic [WW-1:0]     w_last;
  logic [RW_ROW-1:0] h_last;

  assign width_x = WW'(in_width_r);

  always_comb begin
    if (width_x < WW'(3)) begin
      w_last = WW'(2);
    end else if (width_x > WW'(MAX_WIDTH)) begin
      w_last = WW'(MAX_WIDTH - 1);
    end else begin
      w_last = width_x - WW'(1);
    end
    if (in_height_r < sgm_pkg::HEIGHT_MIN) begin
      h_last = sgm_pkg::ROW_LAST_MIN;
    end else if (in_height_r > sgm_pkg::HEIGHT_MAX) begin
      h_last = sgm_pkg::ROW_LAST_MAX;
    end else begin
      h_last = RW_ROW'(in_height_r - 13'd1);
    end
  end

  // Handshake: everything advances together when the output can move.
  logic adv;
  logic accept;
  logic out_vld_r;

  assign adv       = !out_vld_r || out_tready;
  assign accept    = in_tvalid && adv;
  assign in_tready = adv;

  // Position counters.
  logic [CW-1:0]     col_r, col_nxt, col_cur;
  logic [RW_ROW-1:0] row_r, row_nxt, row_cur;
  logic              last_col;
  logic              res_cur;
  logic              lframe_cur;

  assign col_cur    = in_tuser ? '0 : col_r;
  assign row_cur    = in_tuser ? '0 : row_r;
  assign last_col   = (WW'(col_cur) >= w_last);
  assign res_cur    = (col_cur >= CW'(2)) && (row_cur >= sgm_pkg::ROW_FIRST_RES);
  assign lframe_cur = last_col && (row_cur == h_last);

  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = (row_cur >= h_last) ? '0 : row_cur + RW_ROW'(1);
    end else begin
      col_nxt = col_cur + CW'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1: line-store read data arrives.
  logic          s1_vld_r;
  logic          s1_res_r;
  logic [P-1:0]  s1_px_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_lrow_r;
  logic          s1_lframe_r;
  logic          s1_hit_r;
  logic [P-1:0]  s1_fct_r;
  logic [P-1:0]  s1_fcm_r;
  logic          hit_nxt;
  logic [P-1:0]  up_rd, mid_rd;
  logic [P-1:0]  ct, cm, cb;
  logic          s1_wr;

  // A word for the same column right behind its predecessor reads the store
  // in the cycle the predecessor writes it, so the new values are forwarded.
  assign hit_nxt = s1_vld_r && (s1_col_r == col_cur);
  assign ct      = s1_hit_r ? s1_fct_r : up_rd;
  assign cm      = s1_hit_r ? s1_fcm_r : mid_rd;
  assign cb      = s1_px_r;
  assign s1_wr   = s1_vld_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r    <= res_cur;
      s1_px_r     <= in_tdata[P-1:0];
      s1_col_r    <= col_cur;
      s1_lrow_r   <= last_col;
      s1_lframe_r <= lframe_cur;
      s1_hit_r    <= hit_nxt;
      s1_fct_r    <= cm;
      s1_fcm_r    <= s1_px_r;
    end
  end

  sgm_line_store #(.DEPTH(MAX_WIDTH), .DW(P)) u_upper (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (up_rd),
    .wr_en   (s1_wr),
    .wr_addr (s1_col_r),
    .wr_data (cm)
  );

  sgm_line_store #(.DEPTH(MAX_WIDTH), .DW(P)) u_middle (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (mid_rd),
    .wr_en   (s1_wr),
    .wr_addr (s1_col_r),
    .wr_data (cb)
  );

  // Window: entries 0..2 column c-2 top to bottom, 3..5 column c-1.
  logic [P-1:0] win_r [6];

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= ct;
      win_r[4] <= cm;
      win_r[5] <= cb;
    end
  end

  logic [SW-1:0]        right_sum, left_sum, bottom_sum, top_sum;
  logic signed [GW-1:0] gx_nxt, gy_nxt;

  assign right_sum  = SW'(ct) + (SW'(cm) << 1) + SW'(cb);
  assign left_sum   = SW'(win_r[0]) + (SW'(win_r[1]) << 1) + SW'(win_r[2]);
  assign bottom_sum = SW'(win_r[2]) + (SW'(win_r[5]) << 1) + SW'(cb);
  assign top_sum    = SW'(win_r[0]) + (SW'(win_r[3]) << 1) + SW'(ct);
  assign gx_nxt     = en_h_r ? $signed(GW'(right_sum) - GW'(left_sum)) : '0;
  assign gy_nxt     = en_v_r ? $signed(GW'(bottom_sum) - GW'(top_sum)) : '0;

  // Stage 2: gradients registered; absolute values, squares, linear result.
  logic                 s2_vld_r;
  logic signed [GW-1:0] s2_gx_r, s2_gy_r;
  logic                 s2_lrow_r, s2_lframe_r, s2_both_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r && s1_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_gx_r     <= gx_nxt;
      s2_gy_r     <= gy_nxt;
      s2_lrow_r   <= s1_lrow_r;
      s2_lframe_r <= s1_lframe_r;
      s2_both_r   <= en_h_r && en_v_r;
    end
  end

  logic [GW-1:0]        gx_abs, gy_abs;
  logic signed [GW:0]   gsum;
  logic [GW:0]          gsum_abs;
  logic [LXW-1:0]       gsum_x;
  logic [2*SW-1:0]      sqx_nxt, sqy_nxt;
  sgm_pkg::tag_t        tag_nxt;

  assign gx_abs   = s2_gx_r[GW-1] ? (~s2_gx_r + 1'b1) : s2_gx_r;
  assign gy_abs   = s2_gy_r[GW-1] ? (~s2_gy_r + 1'b1) : s2_gy_r;
  assign gsum     = {s2_gx_r[GW-1], s2_gx_r} + {s2_gy_r[GW-1], s2_gy_r};
  assign gsum_abs = gsum[GW] ? (~gsum + 1'b1) : gsum;
  assign gsum_x   = LXW'(gsum_abs);
  assign sqx_nxt  = (2*SW)'(gx_abs[SW-1:0]) * (2*SW)'(gx_abs[SW-1:0]);
  assign sqy_nxt  = (2*SW)'(gy_abs[SW-1:0]) * (2*SW)'(gy_abs[SW-1:0]);

  always_comb begin
    tag_nxt.last_row   = s2_lrow_r;
    tag_nxt.last_frame = s2_lframe_r;
    tag_nxt.both       = s2_both_r;
    tag_nxt.lin_mag    = (gsum_x > LXW'(sgm_pkg::MAG_MAX)) ?
                         sgm_pkg::MAG_MAX : gsum_x[sgm_pkg::MAG_W-1:0];
  end

  // Stage 3: squares registered, summed into the square-root pipeline.
  logic            s3_vld_r;
  logic [2*SW-1:0] s3_sqx_r, s3_sqy_r;
  sgm_pkg::tag_t   s3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sqx_r <= sqx_nxt;
      s3_sqy_r <= sqy_nxt;
      s3_tag_r <= tag_nxt;
    end
  end

  logic          iq_vld;
  logic [RW-1:0] iq_root;
  sgm_pkg::tag_t iq_tag;

  sgm_isqrt #(.RW(RW)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s3_vld_r),
    .in_value  ((2*RW)'(s3_sqx_r) + (2*RW)'(s3_sqy_r)),
    .in_tag    (s3_tag_r),
    .out_valid (iq_vld),
    .out_root  (iq_root),
    .out_tag   (iq_tag)
  );

  // Scale by 100/141 with a reciprocal multiply; saturate large roots.
  logic [RXW-1:0]              root_x;
  logic                        root_sat;
  logic [PW-1:0]               scaled;
  logic [sgm_pkg::MAG_W-1:0]   mag_nxt;

  assign root_x   = RXW'(iq_root);
  assign root_sat = (root_x >= RXW'(sgm_pkg::ROOT_SAT));
  assign scaled   = PW'(root_x[sgm_pkg::ROOT_USE_W-1:0]) * PW'(sgm_pkg::SCALE_MUL);

  always_comb begin
    if (!iq_tag.both) begin
      mag_nxt = iq_tag.lin_mag;
    end else if (root_sat) begin
      mag_nxt = sgm_pkg::MAG_MAX;
    end else begin
      mag_nxt = scaled[sgm_pkg::SCALE_SHIFT +: sgm_pkg::MAG_W];
    end
  end

  // Output register.
  logic [sgm_pkg::MAG_W-1:0] out_mag_r;
  logic                      out_lrow_r;
  logic                      out_lframe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= iq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && iq_vld) begin
      out_mag_r    <= mag_nxt;
      out_lrow_r   <= iq_tag.last_row;
      out_lframe_r <= iq_tag.last_frame;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = sgm_pkg::OUT_DW'(out_mag_r);
  assign out_tlast  = out_lrow_r;
  assign out_tuser  = out_lframe_r;

endmodule

FILE: hw/rtl/sgm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "sobel_gradient_magnitude_unit_macros.svh"

module sgm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [sgm_pkg::OUT_DW-1:0] out_tdata,
  input logic                       out_tlast,
  input logic                       out_tuser
);

  // No word may come out of reset.
  `SGM_ASSERT_AFTER_RESET(a_quiet_after_reset, clk, rst_n, !out_tvalid)

  // The input side only stalls behind a held output word.
  `SGM_ASSERT_SAME(a_ready_tracks_output, clk, rst_n, !in_tready, out_tvalid && !out_tready)

  // A frame always ends at the end of a row.
  `SGM_ASSERT_SAME(a_frame_end_on_row_end, clk, rst_n, out_tvalid && out_tuser, out_tlast)

  // A stalled output word stays put.
  `SGM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind sobel_gradient_magnitude_unit sgm_checker u_sgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
